@@ sv/uhv_pkg.sv @@
// ----------------------------------------------------------------------------
// uhv_pkg: shared types and helpers of the URL host validator
// Holds the scan state record, the transfer records between the stages
// and the per-byte update function.
// ----------------------------------------------------------------------------
`default_nettype none

package uhv_pkg;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [1:0] RegionPrefix = 2'd0;
  localparam logic [1:0] RegionHost   = 2'd1;
  localparam logic [1:0] RegionPath   = 2'd2;

  localparam logic [3:0] LocalLen      = 4'd9;
  localparam logic [3:0] LocalMismatch = 4'd15;
  localparam logic [1:0] LabelSat      = 2'd3;
  localparam logic [1:0] LabelMin      = 2'd2;

  typedef struct packed {
    logic [1:0] region;
    logic [1:0] sep_match;
    logic       scheme_found;
    logic       prefix_all_alpha;
    logic       alpha_before_colon;
    logic       host_chars_ok;
    logic       host_nonempty;
    logic       colon_seen;
    logic       dot_seen;
    logic [1:0] label_length;
    logic       label_all_alpha;
    logic [3:0] localhost_index;
    logic       port_all_digits;
  } uhv_state_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } uhv_item_t;

  typedef struct packed {
    logic scheme_absent;
    logic valid_res;
  } uhv_res_t;

  localparam uhv_state_t StateReset = '{
    region:             RegionPrefix,
    sep_match:          2'd0,
    scheme_found:       1'b0,
    prefix_all_alpha:   1'b1,
    alpha_before_colon: 1'b1,
    host_chars_ok:      1'b1,
    host_nonempty:      1'b0,
    colon_seen:         1'b0,
    dot_seen:           1'b0,
    label_length:       2'd0,
    label_all_alpha:    1'b1,
    localhost_index:    4'd0,
    port_all_digits:    1'b1
  };

  function automatic logic uhv_is_alpha(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= 8'h61) && (l <= 8'h7A);
  endfunction

  function automatic logic uhv_is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic uhv_is_ws(logic [7:0] c);
    return ((c >= 8'h09) && (c <= 8'h0D)) || (c == ChSpace);
  endfunction

  // Letters of "localhost" by position.
  function automatic logic [7:0] uhv_local_char(logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h6C;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h63;
      4'd3:    ch = 8'h61;
      4'd4:    ch = 8'h6C;
      4'd5:    ch = 8'h68;
      4'd6:    ch = 8'h6F;
      4'd7:    ch = 8'h73;
      4'd8:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Applies one byte of trimmed URL text to the scan state.
  function automatic uhv_state_t uhv_feed(uhv_state_t s, logic [7:0] c);
    uhv_state_t n;
    logic       found;
    n     = s;
    found = 1'b0;
    if (!s.scheme_found) begin
      if (c == ChColon) begin
        n.alpha_before_colon = s.prefix_all_alpha;
        n.sep_match          = 2'd1;
      end else if (c == ChSlash) begin
        if (s.sep_match == 2'd2) begin
          found = 1'b1;
        end else begin
          n.sep_match = (s.sep_match == 2'd1) ? 2'd2 : 2'd0;
        end
      end else begin
        n.sep_match = 2'd0;
      end
      n.prefix_all_alpha = s.prefix_all_alpha && uhv_is_alpha(c);
    end
    if (found) begin
      n                  = StateReset;
      n.scheme_found     = 1'b1;
      n.alpha_before_colon = s.alpha_before_colon;
      n.prefix_all_alpha = s.alpha_before_colon;
      n.region           = RegionHost;
    end else if (s.region[1]) begin
      // Path bytes are ignored.
    end else if (c == ChSlash) begin
      n.region = RegionPath;
    end else if (c == ChColon) begin
      if (s.colon_seen) n.host_chars_ok = 1'b0;
      n.colon_seen      = 1'b1;
      n.port_all_digits = 1'b1;
    end else if (s.colon_seen) begin
      if (!uhv_is_digit(c)) n.port_all_digits = 1'b0;
    end else begin
      n.host_nonempty = 1'b1;
      if (!(uhv_is_alpha(c) || uhv_is_digit(c) || c == ChDot || c == ChDash)) begin
        n.host_chars_ok = 1'b0;
      end
      if (c == ChDot) begin
        n.dot_seen        = 1'b1;
        n.label_length    = 2'd0;
        n.label_all_alpha = 1'b1;
      end else begin
        if (s.label_length < LabelSat) n.label_length = s.label_length + 2'd1;
        if (!uhv_is_alpha(c)) n.label_all_alpha = 1'b0;
      end
      if ((s.localhost_index < LocalLen) && (c == uhv_local_char(s.localhost_index))) begin
        n.localhost_index = s.localhost_index + 4'd1;
      end else begin
        n.localhost_index = LocalMismatch;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/url_host_validator_unit.sv @@
// ----------------------------------------------------------------------------
// url_host_validator_unit: streaming URL host validator
// Checks a URL that arrives one byte per transfer and returns one verdict
// transfer for the byte marked with tlast.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, URL after URL, except while a
// last byte waits for the result register to free up. A byte lands in an
// input register; from there the scan stage folds it into the scheme, host,
// label, localhost and port flags and, for the last byte, forms the verdict
// into the result register, which offers it downstream until it is taken.
// The scan stage reads the byte from the input register and can apply up to
// two characters in one cycle (a collapsed blank run plus the byte that ends
// it), which is what allows the one-byte-per-cycle rate. Leading and trailing
// blanks are trimmed; the scheme is the text before the first "://" and must
// be all letters; the host ends at the first '/' and is split at its first
// ':' into host name and port. Bytes that are not the last produce no output
// transfer and keep flowing while a verdict waits downstream; only a last
// byte waits for the result register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module url_host_validator_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  wire logic       s_axis_tlast,   // is_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] valid_res, [1] scheme_absent, [7:2] zero
);
  import uhv_pkg::*;

  uhv_item_t in_item, held_item;
  logic      held_valid;
  logic      out_free;
  logic      advance;
  logic      res_valid;
  uhv_res_t  res, out_res;

  assign in_item.char_byte = s_axis_tdata;
  assign in_item.is_last   = s_axis_tlast;

  // A held byte moves on unless it is a last byte and the verdict slot cannot take it.
  assign advance = held_valid && (!held_item.is_last || out_free);

  uhv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (advance),
    .item_o  (held_item)
  );

  uhv_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  uhv_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (out_free),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.scheme_absent, out_res.valid_res};

  // With the input register empty the block always takes a new byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_valid |-> s_axis_tready)
    else $error("url_host_validator_unit: input stalled while empty");

endmodule

`default_nettype wire

@@ sv/uhv_in_reg.sv @@
// ----------------------------------------------------------------------------
// uhv_in_reg: input register
// Captures one byte transfer and holds it until the scan stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uhv_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire uhv_pkg::uhv_item_t item_i,
  output logic                   valid_o,
  input  wire logic              take_i,
  output uhv_pkg::uhv_item_t     item_o
);
  import uhv_pkg::*;

  logic      valid_q, valid_d;
  uhv_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ sv/uhv_scan.sv @@
// ----------------------------------------------------------------------------
// uhv_scan: scan state and per-byte checks
// Folds each byte into the scheme, host and port flags and forms the verdict
// at the last byte of a URL.
// ----------------------------------------------------------------------------
`default_nettype none

module uhv_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire uhv_pkg::uhv_item_t  item_i,
  output logic                    res_valid_o,
  output uhv_pkg::uhv_res_t       res_o
);
  import uhv_pkg::*;

  uhv_state_t state_q, state_d, state_sp, state_ch;
  logic       pending_q, pending_d;
  logic       started_q, started_d;
  logic       ws;
  logic       tld_ok;

  // A whitespace run inside the URL is replayed as one space before the
  // next non-blank byte; trailing blanks never reach the state.
  always_comb begin
    ws       = uhv_is_ws(item_i.char_byte);
    state_sp = pending_q ? uhv_feed(state_q, ChSpace) : state_q;
    state_ch = ws ? state_q : uhv_feed(state_sp, item_i.char_byte);
  end

  always_comb begin
    tld_ok = (state_ch.localhost_index == LocalLen) ||
             (state_ch.dot_seen && (state_ch.label_length >= LabelMin) &&
              state_ch.label_all_alpha);
    res_o.valid_res = state_ch.host_nonempty && state_ch.host_chars_ok && tld_ok &&
                      (!state_ch.scheme_found || state_ch.prefix_all_alpha) &&
                      state_ch.port_all_digits;
    res_o.scheme_absent = !state_ch.scheme_found;
    res_valid_o         = step_i && item_i.is_last;
  end

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    started_d = started_q;
    if (step_i) begin
      if (item_i.is_last) begin
        state_d   = StateReset;
        pending_d = 1'b0;
        started_d = 1'b0;
      end else begin
        state_d   = state_ch;
        pending_d = ws ? (pending_q || started_q) : 1'b0;
        started_d = started_q || !ws;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateReset;
      pending_q <= 1'b0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      started_q <= started_d;
    end
  end

  // A blank can only be pending once some text has been seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> started_q)
    else $error("uhv_scan: pending blank without started text");

  // The localhost matcher holds a position in the word or the mismatch mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.localhost_index <= LocalLen) || (state_q.localhost_index == LocalMismatch))
    else $error("uhv_scan: localhost index out of range");

  // After the last byte all scan state is back at its reset value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == StateReset) && !started_q)
    else $error("uhv_scan: state not cleared after last byte");

endmodule

`default_nettype wire

@@ sv/uhv_out_reg.sv @@
// ----------------------------------------------------------------------------
// uhv_out_reg: result register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uhv_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire uhv_pkg::uhv_res_t  res_i,
  input  wire logic              ready_i,
  output logic                   valid_o,
  output logic                   free_o,
  output uhv_pkg::uhv_res_t      res_o
);
  import uhv_pkg::*;

  logic     valid_q, valid_d;
  uhv_res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // A new verdict never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("uhv_out_reg: verdict overwritten");

endmodule

`default_nettype wire
